### rtl/core/smtn_pkg.sv
// ----------------------------------------------------------------------------
// smtn_pkg
// Shared types and codes for the sorted multiset neighbour take-out block.
// ----------------------------------------------------------------------------
package smtn_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_W        = 32;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SUCC   = 2'd1;
	localparam logic [1:0] REQ_PRED   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DECIDE,
		S_MOVE,
		S_REPLY
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic do_insert;
		logic set_full;
		logic set_none;
		logic scan_start;
		logic scan_step;
		logic fetch_last;
		logic do_move;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       full;
		logic       empty;
		logic       scan_last;
		logic       found;
	} dp_stat_t;

endpackage

### rtl/core/smtn_ram.sv
// ----------------------------------------------------------------------------
// smtn_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module smtn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/smtn_ctrl.sv
// ----------------------------------------------------------------------------
// smtn_ctrl
// Request sequencer: dispatch, linear scan of the key store, removal, reply.
// ----------------------------------------------------------------------------
module smtn_ctrl
	import smtn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (stat.req_type)
					REQ_SUCC, REQ_PRED: begin
						state_d = stat.empty ? S_REPLY : S_SCAN;
					end
					default: state_d = S_REPLY;
				endcase
			end
			S_SCAN: begin
				if (stat.scan_last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = stat.found ? S_MOVE : S_REPLY;
			end
			S_MOVE:  state_d = S_REPLY;
			S_REPLY: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		done = (state_q == S_REPLY);
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = start;
			end
			S_DISPATCH: begin
				unique case (stat.req_type)
					REQ_INSERT: begin
						if (stat.full) cmd.set_full = 1'b1;
						else cmd.do_insert = 1'b1;
					end
					REQ_SUCC, REQ_PRED: begin
						if (stat.empty) cmd.set_none = 1'b1;
						else cmd.scan_start = 1'b1;
					end
					default: cmd.set_none = 1'b1;
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_DECIDE: begin
				if (stat.found) cmd.fetch_last = 1'b1;
				else cmd.set_none = 1'b1;
			end
			S_MOVE: begin
				cmd.do_move = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/smtn_dp.sv
// ----------------------------------------------------------------------------
// smtn_dp
// Key store, occupancy count, scan compare and best-candidate registers.
// ----------------------------------------------------------------------------
module smtn_dp
	import smtn_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_cmd_t               cmd,
	input  logic [1:0]              req_type,
	input  logic signed [KEY_W-1:0] key,
	output dp_stat_t                stat,
	output logic [1:0]              status,
	output logic signed [KEY_W-1:0] taken_key
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int OCC_W = $clog2(CAPACITY + 1);

	logic [1:0]              req_q;
	logic signed [KEY_W-1:0] key_q;
	logic [OCC_W-1:0]        occ_q;
	logic [AW-1:0]           scan_idx_q;
	logic                    found_q;
	logic signed [KEY_W-1:0] best_q;
	logic [AW-1:0]           best_idx_q;
	logic [1:0]              status_q;
	logic signed [KEY_W-1:0] taken_q;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [KEY_W-1:0]        wr_data;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [KEY_W-1:0]        rd_raw;
	logic signed [KEY_W-1:0] rd_key;
	logic [AW-1:0]           last_idx;
	logic                    better;

	assign rd_key   = $signed(rd_raw);
	assign last_idx = AW'(occ_q - OCC_W'(1));

	// candidate test for the entry now on the read port
	always_comb begin
		if (req_q == REQ_SUCC) begin
			better = (rd_key > key_q) && (!found_q || (rd_key < best_q));
		end else begin
			better = (rd_key <= key_q) && (!found_q || (rd_key > best_q));
		end
	end

	// removal moves the last stored key into the hole, order is not kept
	always_comb begin
		wr_en   = cmd.do_insert | cmd.do_move;
		wr_addr = cmd.do_move ? best_idx_q : AW'(occ_q);
		wr_data = cmd.do_move ? rd_raw : key_q;
		rd_en   = cmd.scan_start | cmd.scan_step | cmd.fetch_last;
		priority if (cmd.fetch_last) begin
			rd_addr = last_idx;
		end else if (cmd.scan_step) begin
			rd_addr = scan_idx_q + AW'(1);
		end else begin
			rd_addr = '0;
		end
	end

	smtn_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.do_insert) occ_q <= occ_q + OCC_W'(1);
			if (cmd.do_move) occ_q <= occ_q - OCC_W'(1);
			if (cmd.scan_start) begin
				found_q <= 1'b0;
			end else if (cmd.scan_step && better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			key_q <= key;
		end
		if (cmd.scan_start) begin
			scan_idx_q <= '0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + AW'(1);
		end
		if (cmd.scan_step && better) begin
			best_q     <= rd_key;
			best_idx_q <= scan_idx_q;
		end
		if (cmd.do_insert) begin
			status_q <= ST_OK;
			taken_q  <= '0;
		end
		if (cmd.set_full) begin
			status_q <= ST_FULL;
			taken_q  <= '0;
		end
		if (cmd.set_none) begin
			status_q <= ST_NONE;
			taken_q  <= '0;
		end
		if (cmd.do_move) begin
			status_q <= ST_OK;
			taken_q  <= best_q;
		end
	end

	always_comb begin
		stat.req_type  = req_q;
		stat.full      = (occ_q == OCC_W'(CAPACITY));
		stat.empty     = (occ_q == '0);
		stat.scan_last = (scan_idx_q == last_idx);
		stat.found     = found_q;
	end

	assign status    = status_q;
	assign taken_key = taken_q;

endmodule

### rtl/core/sorted_multiset_take_neighbour.sv
// insert, full table, empty table or unused code: dispatch, then the result strobe
// take: dispatch, scan, decide, then move when a key is removed, and the result strobe; the scan
// reads one key per cycle over the store
// a new request is accepted only when idle; busy is low only when waiting
// reset: controller idle, table empty; the key memory itself is not cleared
// the result strobe lasts one cycle and the receiver cannot stall it
// ----------------------------------------------------------------------------
// sorted_multiset_take_neighbour
// Multiset of signed keys with insert and successor / predecessor take-out.
// ----------------------------------------------------------------------------
module sorted_multiset_take_neighbour
	import smtn_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              req_type,
	input  logic signed [KEY_W-1:0] key,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [KEY_W-1:0] taken_key
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	smtn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	smtn_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_type  (req_type),
		.key       (key),
		.stat      (stat),
		.status    (status),
		.taken_key (taken_key)
	);

endmodule

### rtl/core/smtn_checker.sv
// ----------------------------------------------------------------------------
// smtn_checker
// Port-level checks on the request and result timing and result values of the top level.
// ----------------------------------------------------------------------------
module smtn_checker
	import smtn_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [1:0]              status,
	input logic signed [KEY_W-1:0] taken_key
);

	// an accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// result strobe is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// no result without a request in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy && $past(busy))
		else $error("result without request in flight");

	// only successful takes carry a key, and status codes stay in range
	a_taken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> (taken_key == '0) && (status != 2'd3))
		else $error("failed request returned a key or bad status");

endmodule

bind sorted_multiset_take_neighbour smtn_checker u_smtn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.taken_key (taken_key)
);
